// ----- rtl/core/permutation_table_with_inverse_defines.svh -----
// assertion macros for the port-level checker of the permutation table
`ifndef PERMUTATION_TABLE_WITH_INVERSE_DEFINES_SVH
`define PERMUTATION_TABLE_WITH_INVERSE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define PTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define PTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pti_pkg.sv -----
// shared types, widths and command codes of the permutation table
package pti_pkg;

    localparam int PTI_MAX_ELEMENTS = 64;
    localparam int IDX_W            = 6;
    localparam int SIZE_W           = 7;
    localparam int CMD_W            = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_IDENTITY = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SWAP     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_FWD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_INV = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INVERT   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ORBITS   = 3'd6;

    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } pti_map_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_data;
        logic             rd_hit;
    } pti_map_rsp_t;

    typedef struct packed {
        logic [IDX_W-1:0] data;
        logic [IDX_W-1:0] element_index;
        logic             last;
        logic             range_error;
    } pti_result_t;

endpackage

// ----- rtl/core/pti_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module pti_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/pti_map.sv -----
// index store: ram plus per-entry valid bits, unwritten entries read as their own index
module pti_map import pti_pkg::*; #(
    parameter int DEPTH = PTI_MAX_ELEMENTS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  pti_map_req_t req,
    output pti_map_rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             hit_reg;
    logic             hit_next;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    ram_q;

    pti_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr[AW-1:0]),
        .wr_data (req.wr_data[AW-1:0]),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr[AW-1:0]),
        .rd_data (ram_q)
    );

    // clear drops every entry back to its reset value at once
    always_comb
    begin
        valid_next = req.clear ? '0 : valid_reg;
        if (req.wr_en)
        begin
            valid_next[req.wr_addr[AW-1:0]] = 1'b1;
        end
        hit_next = req.rd_en ? valid_reg[req.rd_addr[AW-1:0]] : hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            addr_reg <= req.rd_addr[AW-1:0];
        end
    end

    assign rsp.rd_data = hit_reg ? IDX_W'(ram_q) : IDX_W'(addr_reg);
    assign rsp.rd_hit  = hit_reg;

endmodule

// ----- rtl/core/pti_ctrl.sv -----
// command sequencer: map read-modify-write, orbit walk and output register
module pti_ctrl import pti_pkg::*; #(
    parameter int MAX_ELEMENTS = PTI_MAX_ELEMENTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [IDX_W-1:0]  position,
    input  logic [IDX_W-1:0]  operand_value,
    input  logic [SIZE_W-1:0] size_in_use,
    output logic              out_valid,
    input  logic              out_ready,
    output pti_result_t       result,
    output logic              roles_swapped,
    output pti_map_req_t      f_req,
    input  pti_map_rsp_t      f_rsp,
    output pti_map_req_t      g_req,
    input  pti_map_rsp_t      g_rsp,
    output pti_map_req_t      l_req,
    input  pti_map_rsp_t      l_rsp
);

    localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_ELEMENTS);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_RD_WAIT  = 4'd1;
    localparam logic [3:0] ST_SWAP_V   = 4'd2;
    localparam logic [3:0] ST_SET_AB   = 4'd3;
    localparam logic [3:0] ST_SET_WR2  = 4'd4;
    localparam logic [3:0] ST_EMIT     = 4'd5;
    localparam logic [3:0] ST_ORB_RD   = 4'd6;
    localparam logic [3:0] ST_ORB_CHK  = 4'd7;
    localparam logic [3:0] ST_ORB_EMIT = 4'd8;
    localparam logic [3:0] ST_ORB_WALK = 4'd9;

    logic [3:0]        state_reg,  state_next;
    logic              roles_reg,  roles_next;
    logic              walk_reg,   walk_next;
    logic              oval_reg,   oval_next;
    logic [CMD_W-1:0]  cmd_reg,    cmd_next;
    logic [IDX_W-1:0]  pos_reg,    pos_next;
    logic [IDX_W-1:0]  opv_reg,    opv_next;
    logic [IDX_W-1:0]  i_reg,      i_next;
    pti_result_t       res_reg,    res_next;
    pti_result_t       out_reg,    out_next;

    logic [SIZE_W-1:0] n_eff;
    logic              pos_err;
    logic              opv_err;
    logic              slot_free;
    logic              load_out;

    // size zero acts as one, size above the table depth acts as the depth
    always_comb
    begin
        if (size_in_use == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (size_in_use > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = size_in_use;
        end
    end

    assign pos_err   = {1'b0, position} >= n_eff;
    assign opv_err   = {1'b0, operand_value} >= n_eff;
    assign slot_free = !oval_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        roles_next = roles_reg;
        walk_next  = walk_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        opv_next   = opv_reg;
        i_next     = i_reg;
        res_next   = res_reg;
        load_out   = 1'b0;
        f_req      = '0;
        g_req      = '0;
        l_req      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next               = command;
                    pos_next               = position;
                    opv_next               = operand_value;
                    res_next.data          = '0;
                    res_next.element_index = position;
                    res_next.last          = 1'b1;
                    res_next.range_error   = 1'b0;
                    state_next             = ST_EMIT;
                    unique case (command)
                        CMD_IDENTITY:
                        begin
                            f_req.clear = 1'b1;
                            g_req.clear = 1'b1;
                            roles_next  = 1'b0;
                        end
                        CMD_SET:
                        begin
                            if (pos_err || opv_err)
                            begin
                                res_next.range_error = 1'b1;
                            end
                            else
                            begin
                                f_req.rd_en   = 1'b1;
                                f_req.rd_addr = position;
                                g_req.rd_en   = 1'b1;
                                g_req.rd_addr = operand_value;
                                state_next    = ST_SET_AB;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (pos_err || opv_err)
                            begin
                                res_next.range_error = 1'b1;
                            end
                            else
                            begin
                                f_req.rd_en   = 1'b1;
                                f_req.rd_addr = operand_value;
                                state_next    = ST_SWAP_V;
                            end
                        end
                        CMD_READ_FWD:
                        begin
                            if (pos_err)
                            begin
                                res_next.range_error = 1'b1;
                            end
                            else
                            begin
                                f_req.rd_en   = 1'b1;
                                f_req.rd_addr = position;
                                state_next    = ST_RD_WAIT;
                            end
                        end
                        CMD_READ_INV:
                        begin
                            if (pos_err)
                            begin
                                res_next.range_error = 1'b1;
                            end
                            else
                            begin
                                g_req.rd_en   = 1'b1;
                                g_req.rd_addr = position;
                                state_next    = ST_RD_WAIT;
                            end
                        end
                        CMD_INVERT:
                        begin
                            roles_next = !roles_reg;
                        end
                        CMD_ORBITS:
                        begin
                            l_req.clear = 1'b1;
                            i_next      = '0;
                            state_next  = ST_ORB_RD;
                        end
                        default:
                        begin
                            res_next.data = '0;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                res_next.data = (cmd_reg == CMD_READ_INV) ? g_rsp.rd_data : f_rsp.rd_data;
                state_next    = ST_EMIT;
            end
            ST_SWAP_V:
            begin
                // the value at the second position is placed at the first
                opv_next      = f_rsp.rd_data;
                f_req.rd_en   = 1'b1;
                f_req.rd_addr = pos_reg;
                g_req.rd_en   = 1'b1;
                g_req.rd_addr = f_rsp.rd_data;
                state_next    = ST_SET_AB;
            end
            ST_SET_AB:
            begin
                // the position that held the value takes over the old value
                f_req.wr_en   = 1'b1;
                f_req.wr_addr = g_rsp.rd_data;
                f_req.wr_data = f_rsp.rd_data;
                g_req.wr_en   = 1'b1;
                g_req.wr_addr = f_rsp.rd_data;
                g_req.wr_data = g_rsp.rd_data;
                state_next    = ST_SET_WR2;
            end
            ST_SET_WR2:
            begin
                f_req.wr_en   = 1'b1;
                f_req.wr_addr = pos_reg;
                f_req.wr_data = opv_reg;
                g_req.wr_en   = 1'b1;
                g_req.wr_addr = opv_reg;
                g_req.wr_data = pos_reg;
                res_next.data = (cmd_reg == CMD_SET) ? opv_reg : '0;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ORB_RD:
            begin
                l_req.rd_en   = 1'b1;
                l_req.rd_addr = i_reg;
                state_next    = ST_ORB_CHK;
            end
            ST_ORB_CHK:
            begin
                res_next.element_index = i_reg;
                res_next.range_error   = 1'b0;
                res_next.last          = (({1'b0, i_reg} + SIZE_W'(1)) == n_eff);
                if (l_rsp.rd_hit)
                begin
                    res_next.data = l_rsp.rd_data;
                    walk_next     = 1'b0;
                end
                else
                begin
                    // first unvisited element is the smallest of its cycle
                    res_next.data = i_reg;
                    walk_next     = 1'b1;
                    l_req.wr_en   = 1'b1;
                    l_req.wr_addr = i_reg;
                    l_req.wr_data = i_reg;
                end
                state_next = ST_ORB_EMIT;
            end
            ST_ORB_EMIT:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    if (walk_reg)
                    begin
                        f_req.rd_en   = 1'b1;
                        f_req.rd_addr = i_reg;
                        state_next    = ST_ORB_WALK;
                    end
                    else if (res_reg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_ORB_RD;
                    end
                end
            end
            ST_ORB_WALK:
            begin
                if (f_rsp.rd_data == i_reg)
                begin
                    if (res_reg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_ORB_RD;
                    end
                end
                else
                begin
                    l_req.wr_en   = 1'b1;
                    l_req.wr_addr = f_rsp.rd_data;
                    l_req.wr_data = i_reg;
                    f_req.rd_en   = 1'b1;
                    f_req.rd_addr = f_rsp.rd_data;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        oval_next = oval_reg;
        out_next  = out_reg;
        if (load_out)
        begin
            oval_next = 1'b1;
            out_next  = res_reg;
        end
        else if (out_ready)
        begin
            oval_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            roles_reg <= 1'b0;
            walk_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            roles_reg <= roles_next;
            walk_reg  <= walk_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        opv_reg <= opv_next;
        i_reg   <= i_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid     = oval_reg;
    assign result        = out_reg;
    assign roles_swapped = roles_reg;

endmodule

// ----- rtl/core/permutation_table_with_inverse.sv -----
// top level of the permutation table with forward and inverse maps
//
// Keeps a permutation of the first size_in_use elements as a forward map and an
// inverse map, each in its own ram with registered read, and keeps the two
// consistent on every change. Commands arrive on the s_ stream, one transaction
// each; results leave on the m_ stream through an output register, one
// transaction per result, with tlast on the final one of a command. Items are
// handled one at a time: the next command is taken once the sequencer is back in
// idle, even while a result still waits in the output register. Set reads both
// maps, writes the displaced pair, then writes the placed pair; swap adds one
// more read ahead of these to fetch the second value. Orbits read and emit the
// label of each element, plus one forward-map read per element on the cycle
// walk. Since only one command is in flight no forwarding is needed. Identity
// resets take effect at once through per-entry valid bits, so there is no
// clearing pass after reset. An index at or above the size in use returns data 0
// with range_error set and leaves both maps alone. Invert only flips the role bit
// that says which ram acts as the forward map. The user must write size_in_use
// only while the block is idle; the block itself does not enforce this. An
// identity command is expected after a change.
module permutation_table_with_inverse import pti_pkg::*; #(
    parameter int MAX_ELEMENTS = PTI_MAX_ELEMENTS
) (
    input  logic              clk,
    input  logic              rst_n,
    // command transaction
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,     // position[5:0], operand_value[11:6], zero pad
    input  logic [CMD_W-1:0]  s_tuser,     // command[2:0]
    // result transaction
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,     // data[5:0], element_index[11:6], zero pad
    output logic              m_tlast,     // final result of the command
    output logic [0:0]        m_tuser,     // range_error[0]
    // size_in_use register write
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data
);

    logic [SIZE_W-1:0] size_reg;
    logic              roles;
    pti_result_t       result;

    // logical maps as the sequencer sees them
    pti_map_req_t f_req, g_req, l_req;
    pti_map_rsp_t f_rsp, g_rsp, l_rsp;

    // physical rams, fixed
    pti_map_req_t fwd_req, inv_req;
    pti_map_rsp_t fwd_rsp, inv_rsp;

    // size register, reset to the full table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    pti_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .command       (s_tuser),
        .position      (s_tdata[5:0]),
        .operand_value (s_tdata[11:6]),
        .size_in_use   (size_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .result        (result),
        .roles_swapped (roles),
        .f_req         (f_req),
        .f_rsp         (f_rsp),
        .g_req         (g_req),
        .g_rsp         (g_rsp),
        .l_req         (l_req),
        .l_rsp         (l_rsp)
    );

    // role steering: after an odd number of inverts the inverse ram serves as
    // the forward map and the other way round; roles only change in idle
    always_comb
    begin
        fwd_req = roles ? g_req : f_req;
        inv_req = roles ? f_req : g_req;
        f_rsp   = roles ? inv_rsp : fwd_rsp;
        g_rsp   = roles ? fwd_rsp : inv_rsp;
    end

    // forward map
    pti_map #(
        .DEPTH (MAX_ELEMENTS)
    ) u_fwd_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fwd_req),
        .rsp   (fwd_rsp)
    );

    // inverse map
    pti_map #(
        .DEPTH (MAX_ELEMENTS)
    ) u_inv_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (inv_req),
        .rsp   (inv_rsp)
    );

    // orbit labels; valid bit set means the element was already visited
    pti_map #(
        .DEPTH (MAX_ELEMENTS)
    ) u_label_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (l_req),
        .rsp   (l_rsp)
    );

    // result packing
    assign m_tdata = {4'b0000, result.element_index, result.data};
    assign m_tlast = result.last;
    assign m_tuser = result.range_error;

endmodule

// ----- rtl/core/pti_checker.sv -----
// port-level checker for the permutation table, bound to the top level
`include "permutation_table_with_inverse_defines.svh"

module pti_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser
);

    // a stalled result holds its payload
    `PTI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "result changed while stalled")

    // a range error carries zero data and closes its command
    `PTI_ASSERT_NOW(a_err_shape, m_tvalid && m_tuser[0],
        (m_tdata[5:0] == 6'd0) && m_tlast, "range error result malformed")

    // one command in flight at a time
    `PTI_ASSERT_NEXT(a_one_cmd, s_tvalid && s_tready, !s_tready,
        "command taken while another is in flight")

    // while an orbit run is unfinished no new command is taken
    `PTI_ASSERT_NOW(a_orbit_busy, m_tvalid && !m_tlast, !s_tready,
        "ready during an unfinished orbit run")

endmodule

bind permutation_table_with_inverse pti_checker u_pti_checker (.*);

// ----- tb/permutation_table_with_inverse_checker.sv -----
// result checker of the permutation table: watches both streams, predicts and compares
module permutation_table_with_inverse_checker import pti_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [15:0]       s_tdata,     // position[5:0], operand_value[11:6], zero pad
    input  logic [CMD_W-1:0]  s_tuser,     // command[2:0]
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [15:0]       m_tdata,     // data[5:0], element_index[11:6], zero pad
    input  logic              m_tlast,
    input  logic [0:0]        m_tuser,     // range_error[0]
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    output int                fail_count,
    output int                pending_count,
    output int                result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [IDX_W-1:0]  fwd_ram [PTI_MAX_ELEMENTS];
    logic [IDX_W-1:0]  inv_ram [PTI_MAX_ELEMENTS];
    logic              roles_swapped;
    logic [SIZE_W-1:0] size_reg;
    pti_result_t       result_q [$];

    function automatic int active_size();
        int n = size_reg;
        if (n < 1)
            n = 1;
        if (n > PTI_MAX_ELEMENTS)
            n = PTI_MAX_ELEMENTS;
        return n;
    endfunction

    // logical maps: the role bit picks which array acts as forward
    function automatic logic [IDX_W-1:0] fwd_of(int k);
        return roles_swapped ? inv_ram[k] : fwd_ram[k];
    endfunction

    function automatic logic [IDX_W-1:0] inv_of(int k);
        return roles_swapped ? fwd_ram[k] : inv_ram[k];
    endfunction

    task automatic write_fwd(int k, logic [IDX_W-1:0] v);
        if (roles_swapped)
            inv_ram[k] = v;
        else
            fwd_ram[k] = v;
    endtask

    task automatic write_inv(int k, logic [IDX_W-1:0] v);
        if (roles_swapped)
            fwd_ram[k] = v;
        else
            inv_ram[k] = v;
    endtask

    task automatic load_identity();
        for (int k = 0; k < PTI_MAX_ELEMENTS; k++)
        begin
            fwd_ram[k] = IDX_W'(k);
            inv_ram[k] = IDX_W'(k);
        end
        roles_swapped = 1'b0;
    endtask

    // the position that held v takes over the old value at p
    task automatic place_value(logic [IDX_W-1:0] p, logic [IDX_W-1:0] v);
        logic [IDX_W-1:0] holder;
        logic [IDX_W-1:0] old_val;
        holder  = inv_of(v);
        old_val = fwd_of(p);
        write_fwd(holder, old_val);
        write_inv(old_val, holder);
        write_fwd(p, v);
        write_inv(v, p);
    endtask

    task automatic push_result(logic [IDX_W-1:0] d, logic [IDX_W-1:0] idx, logic lst,
                               logic err);
        pti_result_t r;
        r.data          = d;
        r.element_index = idx;
        r.last          = lst;
        r.range_error   = err;
        result_q.push_back(r);
    endtask

    task automatic predict_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] pos,
                                   logic [IDX_W-1:0] opv);
        int n;
        int j;
        logic [SIZE_W-1:0] orbit_lbl [PTI_MAX_ELEMENTS];
        n = active_size();
        case (cmd)
            CMD_IDENTITY:
            begin
                load_identity();
                push_result('0, pos, 1'b1, 1'b0);
            end
            CMD_SET:
            begin
                if (pos >= n || opv >= n)
                    push_result('0, pos, 1'b1, 1'b1);
                else
                begin
                    place_value(pos, opv);
                    push_result(fwd_of(pos), pos, 1'b1, 1'b0);
                end
            end
            CMD_SWAP:
            begin
                if (pos >= n || opv >= n)
                    push_result('0, pos, 1'b1, 1'b1);
                else
                begin
                    place_value(pos, fwd_of(opv));
                    push_result('0, pos, 1'b1, 1'b0);
                end
            end
            CMD_READ_FWD:
            begin
                if (pos >= n)
                    push_result('0, pos, 1'b1, 1'b1);
                else
                    push_result(fwd_of(pos), pos, 1'b1, 1'b0);
            end
            CMD_READ_INV:
            begin
                if (pos >= n)
                    push_result('0, pos, 1'b1, 1'b1);
                else
                    push_result(inv_of(pos), pos, 1'b1, 1'b0);
            end
            CMD_INVERT:
            begin
                roles_swapped = ~roles_swapped;
                push_result('0, pos, 1'b1, 1'b0);
            end
            CMD_ORBITS:
            begin
                for (int k = 0; k < PTI_MAX_ELEMENTS; k++)
                    orbit_lbl[k] = SIZE_W'(n);
                // walk each cycle from its smallest member; the walk may pass
                // entries at or above n when the size changed without identity
                for (int i = 0; i < n; i++)
                begin
                    j = i;
                    for (int s = 0; s <= PTI_MAX_ELEMENTS && orbit_lbl[j] > i; s++)
                    begin
                        orbit_lbl[j] = SIZE_W'(i);
                        j = fwd_of(j);
                    end
                end
                for (int i = 0; i < n; i++)
                    push_result(orbit_lbl[i][IDX_W-1:0], IDX_W'(i), i == n - 1, 1'b0);
            end
            default:
                push_result('0, pos, 1'b1, 1'b0);
        endcase
    endtask

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string field, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d (result %0d)",
                                      field, got, want, result_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pti_result_t want;
        if (!rst_n)
        begin
            load_identity();
            size_reg      = SIZE_RESET;
            result_q.delete();
            fail_count    = 0;
            pending_count = 0;
            result_count  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                size_reg = cfg_wr_data;
            if (s_tvalid && s_tready)
                predict_command(s_tuser, s_tdata[5:0], s_tdata[11:6]);
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (result_q.size() == 0)
                    report_mismatch($sformatf("unexpected result data %0d index %0d",
                                              m_tdata[5:0], m_tdata[11:6]));
                else
                begin
                    want = result_q.pop_front();
                    check_field("data", m_tdata[5:0], want.data);
                    check_field("element_index", m_tdata[11:6], want.element_index);
                    check_field("last", m_tlast, want.last);
                    check_field("range_error", m_tuser[0], want.range_error);
                end
            end
            pending_count = result_q.size();
        end
    end

endmodule

// ----- tb/permutation_table_with_inverse_tb.sv -----
// top of the permutation table testbench: clock, reset, stimulus and verdict
module permutation_table_with_inverse_tb import pti_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // command code the block does not define, expected to act as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    // generous bound: every item an orbit of 64 results under heavy stalls
    localparam int CYCLE_LIMIT = 600000;
    // long receiver hold-off so the block backs up and stalls its input
    localparam int LONG_HOLD = 300;
    // quiet cycles around register writes and at the end
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 18;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;     // position[5:0], operand_value[11:6], zero pad
    logic [CMD_W-1:0]  s_tuser;     // command[2:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;     // data[5:0], element_index[11:6], zero pad
    logic              m_tlast;
    logic [0:0]        m_tuser;     // range_error[0]
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;

    int fail_count;
    int pending_count;
    int result_count;

    // idling knobs shared by the sender and the receiver process
    int src_idle_pct;
    int snk_stall_pct;
    bit hold_req;

    int cycle_count;
    int directed_items;
    int random_items;
    int size_writes;
    int cur_size;

    permutation_table_with_inverse #(
        .MAX_ELEMENTS(PTI_MAX_ELEMENTS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // prediction and comparison live in the checker beside the block
    permutation_table_with_inverse_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a run that never drains ends here
    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending_count);
        $display("permutation_table_with_inverse_tb: FAIL");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic int eff_size(int s);
        if (s < 1)
            return 1;
        if (s > PTI_MAX_ELEMENTS)
            return PTI_MAX_ELEMENTS;
        return s;
    endfunction

    task automatic set_idle_mode(idle_mode_e mode);
        case (mode)
            IDLE_NONE:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            IDLE_SRC:
            begin
                src_idle_pct  = 48;
                snk_stall_pct = 0;
            end
            IDLE_SNK:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 48;
            end
            default:
            begin
                src_idle_pct  = 9;
                snk_stall_pct = 9;
            end
        endcase
    endtask

    // offer one command transaction, with random idle cycles ahead of it
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] pos,
                            logic [IDX_W-1:0] opv);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, opv, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender goes quiet until every predicted result has come back and the
    // block is back in idle (an orbit walk can outlast its last result)
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0 || !s_tready)
            @(negedge clk);
        @(negedge clk);
    endtask

    // size register is only written with the block idle
    task automatic write_size(int value);
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= SIZE_W'(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_size = eff_size(value);
        size_writes++;
    endtask

    // mostly in range, one in ten anywhere in the field
    function automatic logic [IDX_W-1:0] pick_index(int n);
        if ($urandom_range(9) == 0)
            return IDX_W'($urandom_range(63));
        return IDX_W'($urandom_range(n - 1));
    endfunction

    task automatic send_random();
        int roll;
        logic [CMD_W-1:0] cmd;
        roll = $urandom_range(99);
        if (roll < 26)
            cmd = CMD_SET;
        else if (roll < 46)
            cmd = CMD_SWAP;
        else if (roll < 62)
            cmd = CMD_READ_FWD;
        else if (roll < 78)
            cmd = CMD_READ_INV;
        else if (roll < 86)
            cmd = CMD_ORBITS;
        else if (roll < 92)
            cmd = CMD_INVERT;
        else if (roll < 97)
            cmd = CMD_IDENTITY;
        else
            cmd = CMD_UNUSED;
        send_cmd(cmd, pick_index(cur_size), pick_index(cur_size));
        random_items++;
    endtask

    task automatic send_directed(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] pos,
                                 logic [IDX_W-1:0] opv);
        send_cmd(cmd, pos, opv);
        directed_items++;
    endtask

    initial
    begin
        int phase_size [RANDOM_PHASES];
        phase_size = '{64, 5, 13, 0, 127, 2, 9, 1};

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        hold_req    = 1'b0;
        directed_items = 0;
        random_items   = 0;
        size_writes    = 0;
        cur_size       = PTI_MAX_ELEMENTS;
        set_idle_mode(IDLE_NONE);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: identity after reset, full size
        send_directed(CMD_READ_FWD, 6'd0, 6'd0);
        send_directed(CMD_READ_INV, 6'd63, 6'd63);
        // set moves the displaced value to the old holder of 63
        send_directed(CMD_SET, 6'd0, 6'd63);
        send_directed(CMD_READ_FWD, 6'd63, 6'd0);
        send_directed(CMD_READ_INV, 6'd63, 6'd0);
        send_directed(CMD_SWAP, 6'd1, 6'd62);
        send_directed(CMD_ORBITS, 6'd45, 6'd17);
        // inverted roles, then writes through the swapped maps
        send_directed(CMD_INVERT, 6'd21, 6'd42);
        send_directed(CMD_READ_FWD, 6'd0, 6'd0);
        send_directed(CMD_SET, 6'd5, 6'd7);
        send_directed(CMD_ORBITS, 6'd0, 6'd0);
        send_directed(CMD_UNUSED, 6'd63, 6'd63);
        // identity also clears the role bit
        send_directed(CMD_IDENTITY, 6'd42, 6'd21);
        send_directed(CMD_READ_INV, 6'd0, 6'd0);
        send_directed(CMD_SET, 6'd2, 6'd60);
        send_directed(CMD_SWAP, 6'd10, 6'd20);

        // size zero acts as one; no identity so the walk crosses high entries
        write_size(0);
        send_directed(CMD_ORBITS, 6'd9, 6'd9);
        send_directed(CMD_READ_FWD, 6'd1, 6'd0);
        send_directed(CMD_SET, 6'd0, 6'd0);
        // size above the table acts as the full table
        write_size(127);
        send_directed(CMD_SWAP, 6'd0, 6'd63);
        // shrink without identity: indices at and above n are rejected
        write_size(10);
        send_directed(CMD_READ_FWD, 6'd10, 6'd0);
        send_directed(CMD_SET, 6'd3, 6'd10);
        send_directed(CMD_SWAP, 6'd10, 6'd3);
        send_directed(CMD_READ_INV, 6'd12, 6'd0);
        send_directed(CMD_ORBITS, 6'd0, 6'd0);

        // random phases: new size, identity, then mixed commands
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_idle_mode(idle_mode_e'(ph % 4));
            write_size(phase_size[ph]);
            send_cmd(CMD_IDENTITY, IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63)));
            random_items++;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // receiver blocks for a long stretch while commands keep coming
                if (ph == 0 && k == 4)
                    hold_req = 1'b1;
                // sender stops until the block has nothing left to deliver
                if (ph == 5 && k == 11)
                    wait_drain();
                send_random();
            end
        end

        wait_drain();
        repeat (END_CYCLES) @(negedge clk);

        $display("ran %0d directed and %0d random commands over %0d size settings",
                 directed_items, random_items, size_writes);
        $display("checked %0d results under four idling mixes and a long hold-off",
                 result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("permutation_table_with_inverse_tb: PASS");
        else
            $display("permutation_table_with_inverse_tb: FAIL");
        $finish;
    end

endmodule
